FILE: design/i2cm_pkg.sv
package i2cm_pkg;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'd0,
      ST_START_HI  = 5'd1,
      ST_START_LO  = 5'd2,
      ST_STOP_LO   = 5'd3,
      ST_STOP_HI   = 5'd4,
      ST_RD_LOW    = 5'd5,
      ST_RD_HIGH   = 5'd6,
      ST_RA_LOW    = 5'd7,
      ST_RA_HIGH   = 5'd8,
      ST_WAIT_DATA = 5'd9,
      ST_STOPE_LO  = 5'd10,
      ST_STOPE_HI  = 5'd11,
      ST_ADDR_B0   = 5'd12,
      ST_ADDR_B1   = 5'd13,
      ST_ADDR_B2   = 5'd14,
      ST_ADDR_B3   = 5'd15,
      ST_MHI_B0    = 5'd16,
      ST_MHI_B1    = 5'd17,
      ST_MHI_B2    = 5'd18,
      ST_MHI_B3    = 5'd19,
      ST_MLO_B0    = 5'd20,
      ST_MLO_B1    = 5'd21,
      ST_MLO_B2    = 5'd22,
      ST_MLO_B3    = 5'd23,
      ST_DATA_B0   = 5'd24,
      ST_DATA_B1   = 5'd25,
      ST_DATA_B2   = 5'd26,
      ST_DATA_B3   = 5'd27,
      ST_STOPR_LO  = 5'd28,
      ST_STOPR_HI  = 5'd29
   } step_type;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_BEGIN  = 2'd1,
      OP_SUPPLY = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [1:0] KIND_MEM_WRITE = 2'd0;
   localparam logic [1:0] KIND_MEM_READ  = 2'd1;
   localparam logic [1:0] KIND_TRANSMIT  = 2'd2;
   localparam logic [1:0] KIND_RECEIVE   = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_NACK = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;

   localparam logic [1:0] REG_HALF_BIT = 2'd0;

endpackage

FILE: design/i2c_master_transaction_engine_top.sv
// channel | direction | handshake
// req_    | in        | req_valid / req_stall
// rsp_    | out       | rsp_valid / rsp_stall
// csr_    | in        | APB psel/penable/pwrite, pready always high
// each item passes through a single combinational sequencer step into the
// result register; a new item is taken every cycle unless req_stall is high
// the result register with a skid stage takes one more item while a result waits
// synchronous active-high reset: step idle, pins released, half_bit_ticks = 10
module i2c_master_transaction_engine_top
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [1:0]  req_txn_kind,
   input  logic [6:0]  req_dev_address,
   input  logic [15:0] req_mem_address,
   input  logic        req_wide_address,
   input  logic [15:0] req_byte_count,
   input  logic [7:0]  req_write_byte,
   input  logic        req_sda_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_read_valid,
   output logic        rsp_want_write_byte,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic        rsp_busy_res,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [7:0] rbyte;
      logic       rvalid;
      logic       want;
      logic       done;
      logic [1:0] status;
      logic       busy;
   } rsp_type;

   // state
   step_type    step_ff, step_in;
   logic [15:0] phase_ff, phase_in;
   logic [3:0]  bitc_ff, bitc_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] mem_ff, mem_in;
   logic [6:0]  dev_ff, dev_in;
   logic        wide_ff, wide_in;
   logic [1:0]  kind_ff, kind_in;
   logic        rs_ff, rs_in;
   logic        scl_ff, scl_in, sda_ff, sda_in;
   logic [15:0] half_ff;

   // output buffer: main register plus skid
   rsp_type     out_ff, skid_ff, res;
   logic        out_v_ff, skid_v_ff;
   logic        accept;

   assign csr_pready = 1'b1;
   assign csr_prdata = {16'd0, half_ff};
   assign req_stall  = skid_v_ff;
   assign accept     = req_valid && !req_stall;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= 16'd10;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == {REG_HALF_BIT[1:0]}) begin
         half_ff <= csr_pwdata[15:0];
      end
   end

   // sequencer step
   always_comb begin
      logic        rph;
      logic [15:0] d;
      logic [15:0] pc;
      logic [4:0]  base;
      logic [3:0]  bc;
      logic [7:0]  sb;
      logic [15:0] bl;
      step_in  = step_ff;
      phase_in = phase_ff;
      bitc_in  = bitc_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      mem_in   = mem_ff;
      dev_in   = dev_ff;
      wide_in  = wide_ff;
      kind_in  = kind_ff;
      rs_in    = rs_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      res      = '0;
      rph  = (kind_ff == KIND_RECEIVE) || (kind_ff == KIND_MEM_READ && rs_ff);
      d    = (half_ff == 16'd0) ? 16'd1 : half_ff;
      pc   = phase_ff + 16'd1;
      base = {step_ff[4:2], 2'b00};
      bc   = bitc_ff + 4'd1;
      sb   = {shift_ff[6:0], 1'b0};
      bl   = left_ff - 16'd1;
      case (op_type'(req_operation))
         OP_TICK: begin
            if (step_ff != ST_IDLE && step_ff != ST_WAIT_DATA) begin
               phase_in = pc;
               if (pc >= d) begin
                  phase_in = 16'd0;
                  if (step_ff >= ST_ADDR_B0 && step_ff < ST_STOPR_LO) begin
                     case (step_ff[1:0])
                        2'd0: begin
                           step_in = step_type'(step_ff + 5'd1);
                           scl_in = 1'b1;
                        end
                        2'd1: begin
                           bitc_in = bc;
                           shift_in = sb;
                           scl_in = 1'b0;
                           if (bc < 4'd8) begin
                              step_in = step_type'(base);
                              sda_in = sb[7];
                           end else begin
                              step_in = step_type'(base + 5'd2);
                              sda_in = 1'b1;
                           end
                        end
                        2'd2: begin
                           step_in = step_type'(base + 5'd3);
                           scl_in = 1'b1;
                           sda_in = 1'b1;
                        end
                        default: begin
                           scl_in = 1'b0;
                           if (req_sda_sample) begin
                              step_in = ST_STOPE_LO;
                              sda_in = 1'b0;
                           end else begin
                              sda_in = 1'b1;
                              if (base == ST_ADDR_B0 && rph) begin
                                 bitc_in = 4'd0; shift_in = 8'd0;
                                 step_in = ST_RD_LOW;
                              end else if ((base == ST_ADDR_B0 &&
                                            kind_ff == KIND_TRANSMIT) ||
                                           (base == ST_MLO_B0 &&
                                            kind_ff != KIND_MEM_READ)) begin
                                 step_in = (left_ff == 16'd0) ? ST_STOP_LO
                                                              : ST_WAIT_DATA;
                                 sda_in = (left_ff != 16'd0);
                              end else if (base == ST_ADDR_B0 && wide_ff) begin
                                 bitc_in = 4'd0; shift_in = mem_ff[15:8];
                                 step_in = ST_MHI_B0; sda_in = mem_ff[15];
                              end else if (base == ST_ADDR_B0 ||
                                           base == ST_MHI_B0) begin
                                 bitc_in = 4'd0; shift_in = mem_ff[7:0];
                                 step_in = ST_MLO_B0; sda_in = mem_ff[7];
                              end else if (base == ST_MLO_B0) begin
                                 step_in = ST_STOPR_LO; sda_in = 1'b0;
                              end else begin
                                 left_in = bl;
                                 step_in = (bl == 16'd0) ? ST_STOP_LO
                                                         : ST_WAIT_DATA;
                                 sda_in = (bl != 16'd0);
                              end
                           end
                        end
                     endcase
                  end else begin
                     case (step_ff)
                        ST_START_HI: begin
                           step_in = ST_START_LO; scl_in = 1'b1; sda_in = 1'b0;
                        end
                        ST_START_LO: begin
                           shift_in = {dev_ff, rph};
                           bitc_in = 4'd0;
                           step_in = ST_ADDR_B0;
                           scl_in = 1'b0; sda_in = dev_ff[6];
                        end
                        ST_STOP_LO, ST_STOPE_LO, ST_STOPR_LO: begin
                           step_in = step_type'(step_ff + 5'd1);
                           scl_in = 1'b1; sda_in = 1'b0;
                        end
                        ST_STOP_HI, ST_STOPE_HI: begin
                           step_in = ST_IDLE; scl_in = 1'b1; sda_in = 1'b1;
                           res.done = 1'b1;
                           res.status = (step_ff == ST_STOPE_HI) ? STATUS_NACK
                                                                 : STATUS_OK;
                        end
                        ST_STOPR_HI: begin
                           rs_in = 1'b1;
                           step_in = ST_START_HI; scl_in = 1'b1; sda_in = 1'b1;
                        end
                        ST_RD_LOW: begin
                           step_in = ST_RD_HIGH; scl_in = 1'b1; sda_in = 1'b1;
                        end
                        ST_RD_HIGH: begin
                           shift_in = {shift_ff[6:0], req_sda_sample};
                           bitc_in = bc;
                           scl_in = 1'b0;
                           if (bc < 4'd8) begin
                              step_in = ST_RD_LOW; sda_in = 1'b1;
                           end else begin
                              res.rvalid = 1'b1;
                              res.rbyte = {shift_ff[6:0], req_sda_sample};
                              left_in = bl;
                              step_in = ST_RA_LOW;
                              sda_in = (bl == 16'd0);
                           end
                        end
                        ST_RA_LOW: begin
                           step_in = ST_RA_HIGH; scl_in = 1'b1;
                        end
                        ST_RA_HIGH: begin
                           scl_in = 1'b0;
                           if (left_ff == 16'd0) begin
                              step_in = ST_STOP_LO; sda_in = 1'b0;
                           end else begin
                              bitc_in = 4'd0; shift_in = 8'd0;
                              step_in = ST_RD_LOW; sda_in = 1'b1;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end
         OP_BEGIN: begin
            if (step_ff == ST_IDLE) begin
               mem_in = req_mem_address; dev_in = req_dev_address;
               wide_in = req_wide_address; kind_in = req_txn_kind;
               rs_in = 1'b0;
               left_in = req_byte_count;
               phase_in = 16'd0; bitc_in = 4'd0; shift_in = 8'd0;
               if ((req_txn_kind == KIND_MEM_READ || req_txn_kind == KIND_RECEIVE)
                   && req_byte_count == 16'd0) begin
                  res.done = 1'b1; res.status = STATUS_ZERO;
               end else begin
                  step_in = ST_START_HI; scl_in = 1'b1; sda_in = 1'b1;
               end
            end
         end
         OP_SUPPLY: begin
            if (step_ff == ST_WAIT_DATA) begin
               phase_in = 16'd0;
               shift_in = req_write_byte; bitc_in = 4'd0;
               step_in = ST_DATA_B0; scl_in = 1'b0; sda_in = req_write_byte[7];
            end
         end
         default: ;
      endcase
      res.scl  = scl_in;
      res.sda  = sda_in;
      res.want = (step_in == ST_WAIT_DATA);
      res.busy = (step_in != ST_IDLE);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
         phase_ff <= '0; bitc_ff <= '0; shift_ff <= '0; left_ff <= '0;
         mem_ff <= '0; dev_ff <= '0; wide_ff <= 1'b0; kind_ff <= '0;
         rs_ff <= 1'b0; scl_ff <= 1'b1; sda_ff <= 1'b1;
      end else if (accept) begin
         step_ff <= step_in;
         phase_ff <= phase_in; bitc_ff <= bitc_in; shift_ff <= shift_in;
         left_ff <= left_in; mem_ff <= mem_in; dev_ff <= dev_in;
         wide_ff <= wide_in; kind_ff <= kind_in; rs_ff <= rs_in;
         scl_ff <= scl_in; sda_ff <= sda_in;
      end
   end

   // result register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (!out_v_ff || !rsp_stall) begin
            if (skid_v_ff) begin
               out_v_ff <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= accept;
            end
         end else if (accept) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || !rsp_stall) begin
         out_ff <= skid_v_ff ? skid_ff : res;
      end
      if (accept && out_v_ff && rsp_stall) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_scl_level       = out_ff.scl;
   assign rsp_sda_level       = out_ff.sda;
   assign rsp_read_byte       = out_ff.rbyte;
   assign rsp_read_valid      = out_ff.rvalid;
   assign rsp_want_write_byte = out_ff.want;
   assign rsp_done_res        = out_ff.done;
   assign rsp_status          = out_ff.status;
   assign rsp_busy_res        = out_ff.busy;

endmodule
